// ----- src/hbst_pkg.sv -----
// ----------------------------------------------------------------------------
// hbst_pkg
// Shared types and codes for the hash bucket slot table.
// ----------------------------------------------------------------------------
package hbst_pkg;

  localparam int OP_W     = 3;
  localparam int KEY_W    = 32;
  localparam int VAL_W    = 32;
  localparam int STATUS_W = 2;
  localparam int CNT_W    = 5;

  localparam int Q_DEPTH  = 2;
  localparam int Q_PTR_W  = $clog2(Q_DEPTH);
  localparam int Q_CNT_W  = $clog2(Q_DEPTH + 1);

  localparam logic [OP_W-1:0] OP_LOOKUP = 3'd0;
  localparam logic [OP_W-1:0] OP_INSERT = 3'd1;
  localparam logic [OP_W-1:0] OP_REMOVE = 3'd2;
  localparam logic [OP_W-1:0] OP_DUMP   = 3'd3;
  localparam logic [OP_W-1:0] OP_CLEAR  = 3'd4;

  localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NONE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_DUP  = 2'd2;
  localparam logic [STATUS_W-1:0] ST_FULL = 2'd3;

  typedef enum logic [2:0] {
    K_LOOKUP,
    K_INSERT,
    K_REMOVE,
    K_DUMP,
    K_CLEAR,
    K_NOP
  } kind_t;

  typedef struct packed {
    kind_t              kind;
    logic [KEY_W-1:0]   key;
    logic [VAL_W-1:0]   value;
  } cmd_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [KEY_W-1:0]    key;
    logic [VAL_W-1:0]    value;
    logic                last;
    logic [CNT_W-1:0]    count;
    logic                full;
    logic                empty;
  } res_t;

endpackage

// ----- src/hbst_in_if.sv -----
// ----------------------------------------------------------------------------
// hbst_in_if
// Request channel: op, key and value with valid/ready.
// ----------------------------------------------------------------------------
interface hbst_in_if;
  logic                           valid;
  logic                           ready;
  logic [hbst_pkg::OP_W-1:0]      op;
  logic [hbst_pkg::KEY_W-1:0]     key;
  logic [hbst_pkg::VAL_W-1:0]     value;

  modport source (output valid, op, key, value, input ready);
  modport sink   (input valid, op, key, value, output ready);
endinterface

// ----- src/hbst_out_if.sv -----
// ----------------------------------------------------------------------------
// hbst_out_if
// Result channel: status, entry data, last flag and occupancy.
// ----------------------------------------------------------------------------
interface hbst_out_if;
  logic                           valid;
  logic                           ready;
  logic [hbst_pkg::STATUS_W-1:0]  status;
  logic [hbst_pkg::KEY_W-1:0]     out_key;
  logic [hbst_pkg::VAL_W-1:0]     out_value;
  logic                           last;
  logic [hbst_pkg::CNT_W-1:0]     valid_count;
  logic                           is_full;
  logic                           is_empty;

  modport source (output valid, status, out_key, out_value, last, valid_count, is_full,
                  is_empty, input ready);
  modport sink   (input valid, status, out_key, out_value, last, valid_count, is_full,
                  is_empty, output ready);
endinterface

// ----- src/hash_bucket_slot_table.sv -----
// ----------------------------------------------------------------------------
// hash_bucket_slot_table
// One hash bucket of SLOTS key/value slots with lookup, insert, remove,
// dump and clear.
//
// in_ch carries op/key/value; out_ch carries status, out_key, out_value,
// last, valid_count, is_full, is_empty. Both use valid/ready; a transfer
// happens on a clock edge with both high. Lookup and dump produce one
// result per matching valid slot in slot order (or one not-found result);
// every other op produces exactly one result. last marks an item's final
// result.
// Path: the accepting edge loads the decode register; the item then passes
// through the queue and the slot compare register, and execute writes the
// first result into the output register.
// Insert, remove, clear and undefined ops visit idle and execute once;
// lookup and dump stay in execute for each result. The slot engine works on
// one item at a time; a 2-deep queue lets requests be taken meanwhile.
// Reset (rst_n low, synchronous) empties the bucket and drops all queued
// items. When out_ch.ready is low the result holds and the engine stalls;
// requests keep filling the queue until it is full.
// ----------------------------------------------------------------------------
module hash_bucket_slot_table #(
  parameter int SLOTS      = 16,
  parameter int KEY_BITS   = 32,
  parameter int VALUE_BITS = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  hbst_in_if.sink    in_ch,
  hbst_out_if.source out_ch
);

  logic            fq_valid;
  logic            fq_ready;
  hbst_pkg::cmd_t  fq_cmd;
  logic            qb_valid;
  logic            qb_ready;
  hbst_pkg::cmd_t  qb_cmd;
  logic            res_valid;
  hbst_pkg::res_t  res;

  hbst_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .cmd_valid (fq_valid),
    .cmd_ready (fq_ready),
    .cmd       (fq_cmd)
  );

  hbst_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (fq_valid),
    .push_ready (fq_ready),
    .push_cmd   (fq_cmd),
    .pop_valid  (qb_valid),
    .pop_ready  (qb_ready),
    .pop_cmd    (qb_cmd)
  );

  hbst_back #(
    .SLOTS      (SLOTS),
    .KEY_BITS   (KEY_BITS),
    .VALUE_BITS (VALUE_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (qb_valid),
    .cmd_ready (qb_ready),
    .cmd       (qb_cmd),
    .res_valid (res_valid),
    .res_ready (out_ch.ready),
    .res       (res)
  );

  assign out_ch.valid       = res_valid;
  assign out_ch.status      = res.status;
  assign out_ch.out_key     = res.key;
  assign out_ch.out_value   = res.value;
  assign out_ch.last        = res.last;
  assign out_ch.valid_count = res.count;
  assign out_ch.is_full     = res.full;
  assign out_ch.is_empty    = res.empty;

endmodule

// ----- src/hbst_front.sv -----
// ----------------------------------------------------------------------------
// hbst_front
// Accepts request items, decodes the op and registers the command.
// ----------------------------------------------------------------------------
module hbst_front (
  input  logic               clk,
  input  logic               rst_n,
  hbst_in_if.sink            in_ch,
  output logic               cmd_valid,
  input  logic               cmd_ready,
  output hbst_pkg::cmd_t     cmd
);

  logic            fr_valid_r;
  hbst_pkg::cmd_t  fr_cmd_r;
  hbst_pkg::kind_t kind;

  always_comb begin
    unique case (in_ch.op)
      hbst_pkg::OP_LOOKUP: kind = hbst_pkg::K_LOOKUP;
      hbst_pkg::OP_INSERT: kind = hbst_pkg::K_INSERT;
      hbst_pkg::OP_REMOVE: kind = hbst_pkg::K_REMOVE;
      hbst_pkg::OP_DUMP:   kind = hbst_pkg::K_DUMP;
      hbst_pkg::OP_CLEAR:  kind = hbst_pkg::K_CLEAR;
      default:             kind = hbst_pkg::K_NOP;
    endcase
  end

  assign in_ch.ready = !fr_valid_r || cmd_ready;
  assign cmd_valid   = fr_valid_r;
  assign cmd         = fr_cmd_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fr_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      fr_valid_r <= in_ch.valid;
    end
    if (in_ch.ready && in_ch.valid) begin
      fr_cmd_r.kind  <= kind;
      fr_cmd_r.key   <= in_ch.key;
      fr_cmd_r.value <= in_ch.value;
    end
  end

endmodule

// ----- src/hbst_queue.sv -----
// ----------------------------------------------------------------------------
// hbst_queue
// Short command queue between the decode front and the slot engine.
// ----------------------------------------------------------------------------
module hbst_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push_valid,
  output logic               push_ready,
  input  hbst_pkg::cmd_t     push_cmd,
  output logic               pop_valid,
  input  logic               pop_ready,
  output hbst_pkg::cmd_t     pop_cmd
);

  hbst_pkg::cmd_t                  mem_r [hbst_pkg::Q_DEPTH];
  logic [hbst_pkg::Q_PTR_W-1:0]    wr_ptr_r;
  logic [hbst_pkg::Q_PTR_W-1:0]    rd_ptr_r;
  logic [hbst_pkg::Q_CNT_W-1:0]    cnt_r;
  logic                            do_push;
  logic                            do_pop;

  assign push_ready = cnt_r != hbst_pkg::Q_CNT_W'(hbst_pkg::Q_DEPTH);
  assign pop_valid  = cnt_r != '0;
  assign pop_cmd    = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (do_pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      if (do_push && !do_pop)      cnt_r <= cnt_r + 1'b1;
      else if (do_pop && !do_push) cnt_r <= cnt_r - 1'b1;
    end
    if (do_push) mem_r[wr_ptr_r] <= push_cmd;
  end

endmodule

// ----- src/hbst_back.sv -----
// ----------------------------------------------------------------------------
// hbst_back
// Slot engine: holds the bucket, compares all slots at once, applies the
// command and streams results through an output register.
// ----------------------------------------------------------------------------
module hbst_back #(
  parameter int SLOTS      = 16,
  parameter int KEY_BITS   = 32,
  parameter int VALUE_BITS = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cmd_valid,
  output logic               cmd_ready,
  input  hbst_pkg::cmd_t     cmd,
  output logic               res_valid,
  input  logic               res_ready,
  output hbst_pkg::res_t     res
);

  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CW = $clog2(SLOTS + 1);

  typedef enum logic {B_IDLE, B_EXEC} bstate_t;

  bstate_t                 state_r;
  logic [KEY_BITS-1:0]     keys_r [SLOTS];
  logic [VALUE_BITS-1:0]   vals_r [SLOTS];
  logic [SLOTS-1:0]        valid_r;
  logic [CW-1:0]           cnt_r;
  logic [SLOTS-1:0]        hit_r;
  hbst_pkg::cmd_t          cmd_r;
  logic                    out_valid_r;
  hbst_pkg::res_t          res_r;

  logic [KEY_BITS-1:0]     head_k;
  logic [VALUE_BITS-1:0]   head_v;
  logic [KEY_BITS-1:0]     cur_k;
  logic [VALUE_BITS-1:0]   cur_v;
  logic [SLOTS-1:0]        key_eq;
  logic [SLOTS-1:0]        kv_eq;
  logic [SLOTS-1:0]        sel_hit;
  logic [SLOTS-1:0]        low_hit;
  logic [SLOTS-1:0]        rest_hit;
  logic [SLOTS-1:0]        free_oh;
  logic [IW-1:0]           hit_idx;
  logic                    out_free;
  logic                    fire;
  logic                    any_hit;
  logic                    do_ins;
  logic                    do_rem;
  logic                    do_clr;
  logic                    is_scan;
  logic [CW-1:0]           cnt_nxt;
  hbst_pkg::res_t          res_nxt;

  assign head_k = KEY_BITS'(cmd.key);
  assign head_v = VALUE_BITS'(cmd.value);
  assign cur_k  = KEY_BITS'(cmd_r.key);
  assign cur_v  = VALUE_BITS'(cmd_r.value);

  always_comb begin
    for (int s = 0; s < SLOTS; s++) begin
      key_eq[s] = valid_r[s] && (keys_r[s] == head_k);
      kv_eq[s]  = key_eq[s] && (vals_r[s] == head_v);
    end
  end

  always_comb begin
    unique case (cmd.kind)
      hbst_pkg::K_LOOKUP: sel_hit = key_eq;
      hbst_pkg::K_DUMP:   sel_hit = valid_r;
      default:            sel_hit = kv_eq;
    endcase
  end

  assign low_hit  = hit_r & (~hit_r + 1'b1);
  assign rest_hit = hit_r & ~low_hit;
  assign free_oh  = ~valid_r & (valid_r + 1'b1);
  assign any_hit  = |hit_r;

  always_comb begin
    hit_idx = '0;
    for (int s = 0; s < SLOTS; s++) begin
      if (low_hit[s]) hit_idx = hit_idx | IW'(s);
    end
  end

  assign out_free  = !out_valid_r || res_ready;
  assign fire      = (state_r == B_EXEC) && out_free;
  assign cmd_ready = (state_r == B_IDLE);
  assign is_scan   = (cmd_r.kind == hbst_pkg::K_LOOKUP) || (cmd_r.kind == hbst_pkg::K_DUMP);
  assign do_ins    = fire && (cmd_r.kind == hbst_pkg::K_INSERT) && !any_hit && !(&valid_r);
  assign do_rem    = fire && (cmd_r.kind == hbst_pkg::K_REMOVE) && any_hit;
  assign do_clr    = fire && (cmd_r.kind == hbst_pkg::K_CLEAR);

  always_comb begin
    cnt_nxt = cnt_r;
    if (do_ins)      cnt_nxt = cnt_r + 1'b1;
    else if (do_rem) cnt_nxt = cnt_r - 1'b1;
    else if (do_clr) cnt_nxt = '0;
  end

  always_comb begin
    res_nxt.status = hbst_pkg::ST_NONE;
    res_nxt.key    = cmd_r.key;
    res_nxt.value  = '0;
    res_nxt.last   = 1'b1;
    res_nxt.count  = hbst_pkg::CNT_W'(cnt_nxt);
    res_nxt.full   = cnt_nxt == CW'(SLOTS);
    res_nxt.empty  = cnt_nxt == '0;
    unique case (cmd_r.kind)
      hbst_pkg::K_LOOKUP, hbst_pkg::K_DUMP: begin
        if (any_hit) begin
          res_nxt.status = hbst_pkg::ST_OK;
          res_nxt.value  = hbst_pkg::VAL_W'(vals_r[hit_idx]);
          res_nxt.last   = rest_hit == '0;
          if (cmd_r.kind == hbst_pkg::K_DUMP) res_nxt.key = hbst_pkg::KEY_W'(keys_r[hit_idx]);
        end
      end
      hbst_pkg::K_INSERT: begin
        res_nxt.value = cmd_r.value;
        if (any_hit)           res_nxt.status = hbst_pkg::ST_DUP;
        else if (&valid_r)     res_nxt.status = hbst_pkg::ST_FULL;
        else                   res_nxt.status = hbst_pkg::ST_OK;
      end
      hbst_pkg::K_REMOVE: begin
        res_nxt.value  = cmd_r.value;
        res_nxt.status = any_hit ? hbst_pkg::ST_OK : hbst_pkg::ST_NONE;
      end
      hbst_pkg::K_CLEAR: res_nxt.status = hbst_pkg::ST_OK;
      default:           res_nxt.status = hbst_pkg::ST_NONE;
    endcase
  end

  assign res_valid = out_valid_r;
  assign res       = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      out_valid_r <= 1'b0;
      valid_r     <= '0;
      cnt_r       <= '0;
    end else begin
      if (fire)           out_valid_r <= 1'b1;
      else if (res_ready) out_valid_r <= 1'b0;
      unique case (state_r)
        B_IDLE: begin
          if (cmd_valid) begin
            cmd_r   <= cmd;
            hit_r   <= sel_hit;
            state_r <= B_EXEC;
          end
        end
        B_EXEC: begin
          if (fire) begin
            res_r       <= res_nxt;
            cnt_r       <= cnt_nxt;
            hit_r       <= rest_hit;
            if (!is_scan || !any_hit || (rest_hit == '0)) state_r <= B_IDLE;
            if (do_clr) valid_r <= '0;
            for (int s = 0; s < SLOTS; s++) begin
              if (do_ins && free_oh[s]) begin
                valid_r[s] <= 1'b1;
                keys_r[s]  <= cur_k;
                vals_r[s]  <= cur_v;
              end
              if (do_rem && low_hit[s]) valid_r[s] <= 1'b0;
            end
          end
        end
        default: state_r <= B_IDLE;
      endcase
    end
  end

endmodule

// ----- src/hbst_checker.sv -----
// ----------------------------------------------------------------------------
// hbst_checker
// Port-level checks on the result channel of the bucket table.
// ----------------------------------------------------------------------------
module hbst_checker #(
  parameter int SLOTS = 16
) (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic [hbst_pkg::STATUS_W-1:0]  status,
  input logic                           last,
  input logic [hbst_pkg::CNT_W-1:0]     valid_count,
  input logic                           is_full,
  input logic                           is_empty
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(status) && $stable(last))
    else $error("result changed while stalled");

  a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (status != hbst_pkg::ST_OK) |-> last)
    else $error("error or not-found result not marked last");

  a_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && is_empty |-> (valid_count == '0) && !is_full)
    else $error("empty flag disagrees with count");

  a_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && is_full |-> valid_count == hbst_pkg::CNT_W'(SLOTS))
    else $error("full flag disagrees with count");

endmodule

bind hash_bucket_slot_table hbst_checker #(.SLOTS(SLOTS)) u_hbst_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .status      (out_ch.status),
  .last        (out_ch.last),
  .valid_count (out_ch.valid_count),
  .is_full     (out_ch.is_full),
  .is_empty    (out_ch.is_empty)
);
